FILE: hdl/ddm_pkg.sv
// package for the decimal digit multiplier: transfer types, constants and
// the shift-and-adjust helper used by every conversion cell
// depends on nothing
package ddm_pkg;

   localparam int OPERAND_BITS_DEF = 32;
   localparam int DIGITS           = 20;
   localparam int DIGITS_PER_WORD  = 10;
   localparam int DIGIT_BITS       = 4;
   localparam int BCD_BITS         = DIGITS * DIGIT_BITS;
   localparam int WORD_BITS        = DIGITS_PER_WORD * DIGIT_BITS;
   localparam int COUNT_BITS       = 5;
   localparam int BITS_PER_CELL    = 4;

   typedef struct packed {
      logic [31:0] multiplicand;
      logic [31:0] multiplier;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  product_low_digits;
      logic [WORD_BITS-1:0]  product_high_digits;
      logic [COUNT_BITS-1:0] digit_count;
   } rsp_type;

   // one double-dabble step: add three to every digit of five or more,
   // then shift left by one bit taking in the next binary bit
   function automatic logic [BCD_BITS-1:0] dabble_step(input logic [BCD_BITS-1:0] bcd,
                                                       input logic bin_bit);
      logic [BCD_BITS-1:0]   adj;
      logic [DIGIT_BITS-1:0] dig;
      adj = bcd;
      for (int d = 0; d < DIGITS; d++) begin
         dig = bcd[d*DIGIT_BITS +: DIGIT_BITS];
         if (dig >= 4'd5) begin
            adj[d*DIGIT_BITS +: DIGIT_BITS] = dig + 4'd3;
         end
      end
      return {adj[BCD_BITS-2:0], bin_bit};
   endfunction

endpackage

FILE: hdl/ddm_cell.sv
// one conversion cell: takes BITS_PER_CELL binary bits into the bcd digits
// and hands the result to the next cell
// depends on ddm_pkg
module ddm_cell
   import ddm_pkg::*;
#(
   parameter int BIN_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic                in_valid,
   input  logic [BCD_BITS-1:0] in_bcd,
   input  logic [BIN_BITS-1:0] in_bin,
   output logic                out_valid,
   output logic [BCD_BITS-1:0] out_bcd,
   output logic [BIN_BITS-1:0] out_bin
);

   logic                valid_ff;
   logic [BCD_BITS-1:0] bcd_ff, bcd_in;
   logic [BIN_BITS-1:0] bin_ff, bin_in;

   // four dependent shift-and-adjust steps
   always_comb begin
      bcd_in = in_bcd;
      bin_in = in_bin;
      for (int s = 0; s < BITS_PER_CELL; s++) begin
         bcd_in = dabble_step(bcd_in, bin_in[BIN_BITS-1]);
         bin_in = {bin_in[BIN_BITS-2:0], 1'b0};
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (take) begin
         bcd_ff <= bcd_in;
         bin_ff <= bin_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bcd   = bcd_ff;
   assign out_bin   = bin_ff;

endmodule

FILE: hdl/decimal_digit_multiplier_unit.sv
// top level of the decimal digit multiplier: binary multiply stage, a chain
// of double-dabble cells and the output register with the digit count
// depends on ddm_pkg and ddm_cell
//
//   channel | ports                       | direction
//   req     | req_valid req_stall req_data | in  (operand pair)
//   rsp     | rsp_valid rsp_stall rsp_data | out (bcd product, digit count)
//
// one operand pair enters per cycle while req_stall is low; the pipeline has
// one multiply stage, one cell per four product bits and one output stage
// every stage has its own valid bit and loads when it is empty or moves on,
// so bubbles close up while the output is stalled
// reset clears the valid bits only
module decimal_digit_multiplier_unit
   import ddm_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int ProdBits = 2 * OPERAND_BITS;
   localparam int Cells    = (ProdBits + BITS_PER_CELL - 1) / BITS_PER_CELL;
   localparam int PadBits  = Cells * BITS_PER_CELL;

   logic [Cells:0]      st_valid;
   logic [BCD_BITS-1:0] st_bcd [Cells+1];
   logic [PadBits-1:0]  st_bin [Cells+1];
   logic [Cells+1:0]    adv;

   logic                mul_valid_ff;
   logic [PadBits-1:0]  mul_prod_ff, mul_prod_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;

   // advance chain from the output back to the input
   always_comb begin
      adv[Cells+1] = !rsp_valid_ff || !rsp_stall;
      for (int k = Cells; k >= 0; k--) begin
         adv[k] = !st_valid[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];

   // binary multiply of the masked operands
   always_comb begin
      logic [ProdBits-1:0] prod;
      prod = req_data.multiplicand[OPERAND_BITS-1:0] * req_data.multiplier[OPERAND_BITS-1:0];
      mul_prod_in = PadBits'(prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (adv[0]) begin
         mul_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mul_prod_ff <= mul_prod_in;
      end
   end

   assign st_valid[0] = mul_valid_ff;
   assign st_bcd[0]   = '0;
   assign st_bin[0]   = mul_prod_ff;

   // chain of conversion cells
   for (genvar g = 0; g < Cells; g++) begin : g_cell
      ddm_cell #(
         .BIN_BITS (PadBits)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .take      (adv[g+1]),
         .in_valid  (st_valid[g]),
         .in_bcd    (st_bcd[g]),
         .in_bin    (st_bin[g]),
         .out_valid (st_valid[g+1]),
         .out_bcd   (st_bcd[g+1]),
         .out_bin   (st_bin[g+1])
      );
   end

   // split digits and count the significant ones
   always_comb begin
      logic [COUNT_BITS-1:0] cnt;
      cnt = COUNT_BITS'(1);
      for (int i = 0; i < DIGITS; i++) begin
         if (st_bcd[Cells][i*DIGIT_BITS +: DIGIT_BITS] != '0) begin
            cnt = COUNT_BITS'(i + 1);
         end
      end
      rsp_in.product_low_digits  = st_bcd[Cells][WORD_BITS-1:0];
      rsp_in.product_high_digits = st_bcd[Cells][BCD_BITS-1:WORD_BITS];
      rsp_in.digit_count         = cnt;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv[Cells+1]) begin
         rsp_valid_ff <= st_valid[Cells];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[Cells+1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: verif/tb_decimal_digit_multiplier_unit.sv
// testbench for decimal_digit_multiplier_unit: operand pairs in, bcd product and digit count out
// depends on ddm_pkg and the unit rtl; predicts each product and checks every transfer in order
`timescale 1ns / 1ps

module tb_decimal_digit_multiplier_unit
   import ddm_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type product_queue[$];
   int      error_count = 0;
   int      sent_count = 0;
   int      checked_count = 0;
   int      idle_cycles = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;

   decimal_digit_multiplier_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // expected bcd product of one operand pair
   function automatic rsp_type bcd_product(input logic [31:0] a, input logic [31:0] b);
      rsp_type     r;
      logic [63:0] p;
      logic [3:0]  d;
      r = '0;
      r.digit_count = 5'd1;
      p = 64'(a) * 64'(b);
      for (int i = 0; i < DIGITS; i++) begin
         d = 4'(p % 64'd10);
         p = p / 64'd10;
         if (d != 4'd0) begin
            r.digit_count = 5'(i + 1);
         end
         if (i < DIGITS_PER_WORD) begin
            r.product_low_digits[i*DIGIT_BITS +: DIGIT_BITS] = d;
         end else begin
            r.product_high_digits[(i-DIGITS_PER_WORD)*DIGIT_BITS +: DIGIT_BITS] = d;
         end
      end
      return r;
   endfunction

   // result checker and receiver stall
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (product_queue.size() == 0) begin
            $display("%0t: result with none expected, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = product_queue.pop_front();
            checked_count++;
            if (rsp_data.product_low_digits !== want.product_low_digits) begin
               $display("%0t: low digits expected %h actual %h", $time,
                        want.product_low_digits, rsp_data.product_low_digits);
               error_count++;
            end
            if (rsp_data.product_high_digits !== want.product_high_digits) begin
               $display("%0t: high digits expected %h actual %h", $time,
                        want.product_high_digits, rsp_data.product_high_digits);
               error_count++;
            end
            if (rsp_data.digit_count !== want.digit_count) begin
               $display("%0t: digit count expected %0d actual %0d", $time,
                        want.digit_count, rsp_data.digit_count);
               error_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("decimal_digit_multiplier_unit test failed");
         $finish;
      end
   end

   // send one operand pair; valid stays high across back-to-back transfers
   task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{multiplicand: a, multiplier: b};
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      product_queue.insert(product_queue.size(), bcd_product(a, b));
      sent_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (product_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // random operand with a bias towards short and boundary values
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(5))
         0: return $urandom_range(99);
         1: return $urandom_range(9999999);
         2: return 32'hFFFF_FFFF - $urandom_range(15);
         3: return 32'd1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // extremes, zero operands and multiples of ten
   task automatic test_directed();
      send_pair(32'd0, 32'd0);
      send_pair(32'd0, 32'hFFFF_FFFF);
      send_pair(32'hFFFF_FFFF, 32'd0);
      send_pair(32'd10, 32'd1);
      send_pair(32'd1, 32'd10);
      send_pair(32'd10, 32'd10);
      send_pair(32'd1, 32'd1);
      send_pair(32'd9, 32'd9);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair(32'hFFFF_FFFF, 32'd1);
      send_pair(32'h8000_0000, 32'h8000_0000);
      send_pair(32'd100000, 32'd100000);
      send_pair(32'hAAAA_AAAA, 32'h5555_5555);
      send_pair(32'h5555_5555, 32'hAAAA_AAAA);
      send_pair(32'd999999999, 32'd999999999);
      send_pair(32'd1000000000, 32'd1000000000);
      drain_results();
   endtask

   // random pairs under one idling profile
   task automatic test_random(input int count, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int i = 0; i < count; i++) begin
         send_pair(pick_operand(), pick_operand());
         if (i == count / 2) begin
            drain_results();
         end
      end
      drain_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(600, 0, 0);
      test_random(450, 78, 0);
      test_random(450, 0, 78);
      test_random(500, 35, 35);
      stall_pct = 0;
      repeat (40) @(posedge clock);
      $display("sent %0d operand pairs, checked %0d products", sent_count, checked_count);
      $display("covered zero operands, extremes and four idling profiles");
      if (error_count == 0 && product_queue.size() == 0) begin
         $display("decimal_digit_multiplier_unit test passed");
      end else begin
         $display("decimal_digit_multiplier_unit test failed");
      end
      $finish;
   end

endmodule
